/* hdl/pfht_pkg.sv */
// Package for the page frame hash table: request and response types,
// operation and status codes, controller states and default sizes.
// Depends on nothing; the remainder unit and the top level use it.
package pfht_pkg;

  // Default table sizes handed to the top level.
  localparam int unsigned BucketsDef = 256;
  localparam int unsigned NodesDef   = 256;

  // Width of the bucket count register and of the hash sum.
  localparam int unsigned CfgW = 9;
  localparam int unsigned SumW = 25;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ERR      = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] file_id;
    logic [23:0] page_number;
    logic [11:0] frame_number;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [11:0] found_frame;
  } resp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_BRD,
    S_HEAD,
    S_NODE,
    S_FREE,
    S_REM1,
    S_REM2,
    S_FIN
  } state_e;

endpackage

/* hdl/pfht_mod.sv */
// Iterative restoring remainder unit: (sum mod divisor), one quotient bit a cycle.
// Depends on pfht_pkg for the operand widths.
module pfht_mod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pfht_pkg::SumW-1:0]  sum_i,
  input  logic [pfht_pkg::CfgW-1:0]  div_i,
  output logic                       done_o,
  output logic [pfht_pkg::CfgW-1:0]  rem_o
);

  localparam int unsigned CntW = $clog2(pfht_pkg::SumW);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [pfht_pkg::SumW-1:0] sum_q, sum_d;
  logic [pfht_pkg::CfgW-1:0] rem_q, rem_d;
  logic [pfht_pkg::CfgW-1:0] div_q, div_d;
  logic [pfht_pkg::CfgW:0]   trial;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, sum_q[pfht_pkg::SumW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sum_d  = sum_i;
      rem_d  = '0;
      div_d  = div_i;
    end else if (busy_q) begin
      sum_d = {sum_q[pfht_pkg::SumW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = pfht_pkg::CfgW'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[pfht_pkg::CfgW-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(pfht_pkg::SumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* hdl/pfht_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// Depends on no package.
module pfht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  parameter int unsigned AddrW = 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/page_frame_hash_table_top.sv */
// Page frame hash table: top level with the chain-walking controller.
// Depends on pfht_pkg, pfht_mod and pfht_ram.
//
// Maps a (file id, page number) key to a frame number through a chained hash
// table held in two synchronous RAMs: one of bucket heads and one of nodes
// (key, frame and link). After reset a clearing pass empties the buckets and
// chains all nodes onto the free list; no request is taken until it ends. One
// request is handled at a time: the key is hashed to a bucket in the bit-serial
// remainder unit, the bucket head is fetched, each chain node visited is read
// from the node RAM, and the request is committed (a lookup directly, an
// insert by taking a node from the free list, a remove by unlinking the node
// and returning it to the free list). A finished response waits in an output
// register, and the next request is accepted while it does.
module page_frame_hash_table_top #(
  parameter int unsigned BUCKETS = pfht_pkg::BucketsDef,
  parameter int unsigned NODES   = pfht_pkg::NodesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pfht_pkg::CfgW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  pfht_pkg::req_t            in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pfht_pkg::resp_t           out_resp_o
);

  localparam int unsigned BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NW   = $clog2(NODES);
  localparam int unsigned LW   = $clog2(NODES + 1);
  localparam int unsigned WW   = 52 + LW;
  localparam int unsigned ClrN = (BUCKETS > NODES) ? BUCKETS : NODES;
  localparam int unsigned CW   = (ClrN > 1) ? $clog2(ClrN) : 1;
  localparam logic [LW-1:0] LinkNone = LW'(NODES);

  pfht_pkg::state_e state_q, state_d;
  pfht_pkg::req_t   req_q, req_d;
  pfht_pkg::resp_t  res_q, res_d;
  pfht_pkg::resp_t  out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic [pfht_pkg::CfgW-1:0] bcnt_q;
  logic [pfht_pkg::CfgW-1:0] div_eff;
  logic [CW-1:0]    clr_q, clr_d;
  logic [BW-1:0]    bkt_q, bkt_d;
  logic [LW-1:0]    cur_q, cur_d;
  logic [LW-1:0]    prev_q, prev_d;
  logic [LW-1:0]    head_q, head_d;
  logic [LW-1:0]    free_q, free_d;
  logic [LW-1:0]    steps_q, steps_d;
  logic [WW-1:0]    prev_word_q, prev_word_d;
  logic [WW-1:0]    cur_word_q, cur_word_d;

  logic             hash_start, hash_done;
  logic [pfht_pkg::CfgW-1:0] hash_rem;
  logic [12:0]      rem_ext;

  logic             b_we, b_re;
  logic [BW-1:0]    b_waddr, b_raddr;
  logic [LW-1:0]    b_wdata, b_rdata;
  logic             n_we, n_re;
  logic [NW-1:0]    n_waddr, n_raddr;
  logic [WW-1:0]    n_wdata, n_rdata;
  logic [LW-1:0]    rd_link;
  logic             rd_match;
  logic             walk_end, walk_hit;

  // Bucket count register; writes are always taken.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= pfht_pkg::CfgW'(256);
    end else if (cfg_valid_i) begin
      bcnt_q <= cfg_data_i;
    end
  end

  // Divisor in use: zero acts as one, and it never exceeds the bucket RAM.
  always_comb begin
    if (bcnt_q == '0) begin
      div_eff = pfht_pkg::CfgW'(1);
    end else if ({4'b0, bcnt_q} > 13'(BUCKETS)) begin
      div_eff = pfht_pkg::CfgW'(BUCKETS);
    end else begin
      div_eff = bcnt_q;
    end
  end

  pfht_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .sum_i   (pfht_pkg::SumW'(in_req_i.file_id) + pfht_pkg::SumW'(in_req_i.page_number)),
    .div_i   (div_eff),
    .done_o  (hash_done),
    .rem_o   (hash_rem)
  );
  assign rem_ext = 13'(hash_rem);

  pfht_ram #(.Width(LW), .Depth(BUCKETS), .AddrW(BW)) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  pfht_ram #(.Width(WW), .Depth(NODES), .AddrW(NW)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .re_i    (n_re),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  // Fields of the node word just read.
  assign rd_link  = n_rdata[LW-1:0];
  assign rd_match = (n_rdata[WW-1 -: 16] == req_q.file_id) &&
                    (n_rdata[WW-17 -: 24] == req_q.page_number);

  // Controller: clearing pass, hash, chain walk and commit.
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    clr_d       = clr_q;
    bkt_d       = bkt_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    head_d      = head_q;
    free_d      = free_q;
    steps_d     = steps_q;
    prev_word_d = prev_word_q;
    cur_word_d  = cur_word_q;
    in_ready_o  = 1'b0;
    hash_start  = 1'b0;
    b_we        = 1'b0;
    b_waddr     = bkt_q;
    b_wdata     = LinkNone;
    b_re        = 1'b0;
    b_raddr     = bkt_q;
    n_we        = 1'b0;
    n_waddr     = cur_q[NW-1:0];
    n_wdata     = cur_word_q;
    n_re        = 1'b0;
    n_raddr     = cur_q[NW-1:0];
    walk_end    = 1'b0;
    walk_hit    = 1'b0;

    unique case (state_q)
      pfht_pkg::S_CLEAR: begin
        if (32'(clr_q) < BUCKETS) begin
          b_we    = 1'b1;
          b_waddr = BW'(clr_q);
          b_wdata = LinkNone;
        end
        if (32'(clr_q) < NODES) begin
          n_we    = 1'b1;
          n_waddr = NW'(clr_q);
          n_wdata = {52'b0, LW'(clr_q) + 1'b1};
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == CW'(ClrN - 1)) begin
          state_d = pfht_pkg::S_IDLE;
        end
      end
      pfht_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d      = in_req_i;
          hash_start = 1'b1;
          state_d    = pfht_pkg::S_HASH;
        end
      end
      pfht_pkg::S_HASH: begin
        if (hash_done) begin
          bkt_d   = rem_ext[BW-1:0];
          state_d = pfht_pkg::S_BRD;
        end
      end
      pfht_pkg::S_BRD: begin
        b_re    = 1'b1;
        state_d = pfht_pkg::S_HEAD;
      end
      pfht_pkg::S_HEAD: begin
        head_d  = b_rdata;
        cur_d   = b_rdata;
        prev_d  = LinkNone;
        steps_d = '0;
        if (b_rdata < LinkNone) begin
          n_re    = 1'b1;
          n_raddr = b_rdata[NW-1:0];
          state_d = pfht_pkg::S_NODE;
        end else begin
          walk_end = 1'b1;
        end
      end
      pfht_pkg::S_NODE: begin
        if (rd_match) begin
          walk_end   = 1'b1;
          walk_hit   = 1'b1;
          cur_word_d = n_rdata;
        end else if ((steps_q + 1'b1 == LinkNone) || !(rd_link < LinkNone)) begin
          walk_end = 1'b1;
        end else begin
          steps_d     = steps_q + 1'b1;
          prev_d      = cur_q;
          prev_word_d = n_rdata;
          cur_d       = rd_link;
          n_re        = 1'b1;
          n_raddr     = rd_link[NW-1:0];
        end
      end
      pfht_pkg::S_FREE: begin
        free_d  = rd_link;
        n_we    = 1'b1;
        n_waddr = free_q[NW-1:0];
        n_wdata = {req_q.file_id, req_q.page_number, req_q.frame_number, head_q};
        b_we    = 1'b1;
        b_wdata = free_q;
        res_d   = '{status: pfht_pkg::ST_OK, found_frame: '0};
        state_d = pfht_pkg::S_FIN;
      end
      pfht_pkg::S_REM1: begin
        if (prev_q < LinkNone) begin
          n_we    = 1'b1;
          n_waddr = prev_q[NW-1:0];
          n_wdata = {prev_word_q[WW-1:LW], cur_word_q[LW-1:0]};
        end else begin
          b_we    = 1'b1;
          b_wdata = cur_word_q[LW-1:0];
        end
        state_d = pfht_pkg::S_REM2;
      end
      pfht_pkg::S_REM2: begin
        n_we    = 1'b1;
        n_waddr = cur_q[NW-1:0];
        n_wdata = {cur_word_q[WW-1:LW], free_q};
        free_d  = cur_q;
        res_d   = '{status: pfht_pkg::ST_OK, found_frame: '0};
        state_d = pfht_pkg::S_FIN;
      end
      pfht_pkg::S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = pfht_pkg::S_IDLE;
        end
      end
      default: state_d = pfht_pkg::S_IDLE;
    endcase

    // Act on the outcome of the chain walk.
    if (walk_end) begin
      res_d   = '{status: pfht_pkg::ST_ERR, found_frame: '0};
      state_d = pfht_pkg::S_FIN;
      unique case (req_q.mode)
        pfht_pkg::MODE_INSERT: begin
          if (!walk_hit && (free_q < LinkNone)) begin
            n_re    = 1'b1;
            n_raddr = free_q[NW-1:0];
            state_d = pfht_pkg::S_FREE;
          end
        end
        pfht_pkg::MODE_LOOKUP: begin
          if (walk_hit) begin
            res_d = '{status: pfht_pkg::ST_OK, found_frame: n_rdata[LW +: 12]};
          end else begin
            res_d = '{status: pfht_pkg::ST_NOTFOUND, found_frame: '0};
          end
        end
        pfht_pkg::MODE_REMOVE: begin
          if (walk_hit) begin
            state_d = pfht_pkg::S_REM1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfht_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      free_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
      free_q      <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    res_q       <= res_d;
    out_q       <= out_d;
    bkt_q       <= bkt_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    head_q      <= head_d;
    steps_q     <= steps_d;
    prev_word_q <= prev_word_d;
    cur_word_q  <= cur_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_resp_o  = out_q;

`ifndef SYNTHESIS
  // No request is taken while the clearing pass runs.
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pfht_pkg::S_CLEAR |-> !in_ready_o)
    else $error("request taken during clearing pass");
  // The free list head is a node or the empty link.
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= LinkNone)
    else $error("free list head out of range");
  // A chain walk only reads real nodes.
  a_walk_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pfht_pkg::S_NODE |-> cur_q < LinkNone)
    else $error("chain walk on empty link");
  // A frame is reported only with an ok status.
  a_frame_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_resp_o.status == pfht_pkg::ST_OK || out_resp_o.found_frame == '0))
    else $error("frame reported with error status");
`endif

endmodule
